@@ rtl/skt_pkg.sv @@
// Shared types and codes for the sorted key table unit.
// No dependencies.
`timescale 1ns / 1ps

package skt_pkg;

   localparam int KEY_W = 24;

   typedef logic [KEY_W-1:0] key_type;

   localparam logic [1:0] ST_FOUND    = 2'd0;
   localparam logic [1:0] ST_INSERTED = 2'd1;
   localparam logic [1:0] ST_ABSENT   = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_INSERT = 1'b1;

   typedef struct packed {
      logic    cmp_en;
      logic    ins_en;
      key_type probe;
   } cell_ctl_type;

endpackage

@@ rtl/skt_ifaces.sv @@
// Valid/ready channel interfaces for request and response items.
// No dependencies.
`timescale 1ns / 1ps

interface skt_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [7:0]  res_type;
   logic [15:0] res_id;

   modport source (output valid, action, res_type, res_id, input ready);
   modport sink   (input valid, action, res_type, res_id, output ready);
endinterface

interface skt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [5:0] slot;

   modport source (output valid, status, slot, input ready);
   modport sink   (input valid, status, slot, output ready);
endinterface

@@ rtl/skt_cell.sv @@
// One slot of the sorted key chain: holds a key, compares it with the probe,
// and on insert loads the probe or left neighbor's key. Depends on skt_pkg.
`timescale 1ns / 1ps

module skt_cell #(
   parameter int CW  = 7,
   parameter int IDX = 0
) (
   input  logic                  clock,
   input  skt_pkg::cell_ctl_type ctl,
   input  logic [CW-1:0]         count,
   input  skt_pkg::key_type      left_key,
   input  logic                  left_lt,
   output skt_pkg::key_type      key,
   output logic                  lt,
   output logic                  eq
);
   import skt_pkg::*;

   localparam logic [CW-1:0] IDX_C = CW'(IDX);

   key_type key_ff, key_in;
   logic    lt_ff, lt_in;
   logic    eq_ff, eq_in;
   logic    occ;
   logic    upto;
   logic    boundary;

   assign occ      = IDX_C < count;
   assign upto     = IDX_C <= count;
   assign boundary = !lt_ff && left_lt;

   always_comb begin
      key_in = key_ff;
      lt_in  = lt_ff;
      eq_in  = eq_ff;
      if (ctl.cmp_en) begin
         lt_in = occ && (key_ff < ctl.probe);
         eq_in = occ && (key_ff == ctl.probe);
      end
      if (ctl.ins_en) begin
         if (boundary) begin
            key_in = ctl.probe;
         end else if (!lt_ff && upto) begin
            key_in = left_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
   end

   assign key = key_ff;
   assign lt  = lt_ff;
   assign eq  = eq_ff;

endmodule

@@ rtl/sorted_key_table_lookup_insert_unit.sv @@
// Top level of the sorted key table: control, entry count and the cell chain.
// Depends on skt_pkg, skt_ifaces and skt_cell.
//
//   channel  dir  payload                       handshake
//   req_ch   in   action, res_type, res_id      valid/ready
//   rsp_ch   out  status, slot                  valid/ready
//
// A request is accepted, all cells compare it with their keys in the next
// cycle, and in the update step that follows the result is registered and an
// insert shifts the chain by one cell. A new request is taken during the
// update step, so compare and update passes over the cells alternate.
// Reset clears the entry count and control; cell keys are not cleared.
// A held response stalls the update step and with it the next request.
`timescale 1ns / 1ps

module sorted_key_table_lookup_insert_unit #(
   parameter int CAPACITY = 64
) (
   input logic       clock,
   input logic       reset,
   skt_req_if.sink   req_ch,
   skt_rsp_if.source rsp_ch
);
   import skt_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = $clog2(CAPACITY);
   localparam int EW = (SW > 6) ? SW : 6;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} state_type;

   state_type    state_ff;
   logic [CW-1:0] count_ff;
   logic         action_ff;
   key_type      probe_ff;
   logic         rsp_valid_ff;
   logic [1:0]   status_ff;
   logic [5:0]   slot_ff;

   cell_ctl_type ctl;
   key_type      cell_key [CAPACITY];
   logic [CAPACITY-1:0] cell_lt;
   logic [CAPACITY-1:0] cell_eq;
   logic [CAPACITY-1:0] boundary;
   logic [CAPACITY-1:0] hit;
   logic [EW-1:0] enc;
   logic         out_free;
   logic         upd_go;
   logic         accept;
   logic         found;
   logic         full;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign upd_go   = (state_ff == S_UPD) && out_free;
   assign req_ch.ready = (state_ff == S_IDLE) || upd_go;
   assign accept   = req_ch.valid && req_ch.ready;
   assign found    = |cell_eq;
   assign full     = (count_ff == CAP_C);

   assign ctl.cmp_en = (state_ff == S_CMP);
   assign ctl.ins_en = upd_go && !found && (action_ff == ACT_INSERT) && !full;
   assign ctl.probe  = probe_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      key_type left_key;
      logic    left_lt;
      if (i == 0) begin : g_first
         assign left_key = '0;
         assign left_lt  = 1'b1;
      end else begin : g_rest
         assign left_key = cell_key[i-1];
         assign left_lt  = cell_lt[i-1];
      end
      assign boundary[i] = !cell_lt[i] && left_lt;

      skt_cell #(.CW(CW), .IDX(i)) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .count    (count_ff),
         .left_key (left_key),
         .left_lt  (left_lt),
         .key      (cell_key[i]),
         .lt       (cell_lt[i]),
         .eq       (cell_eq[i])
      );
   end

   assign hit = found ? cell_eq : boundary;

   always_comb begin
      enc = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (hit[i]) begin
            enc = enc | EW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               state_ff <= S_UPD;
            end
            S_UPD: begin
               if (upd_go) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= accept ? S_CMP : S_IDLE;
                  if (ctl.ins_en) begin
                     count_ff <= count_ff + CW'(1);
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_ch.action;
         probe_ff  <= {req_ch.res_type, req_ch.res_id};
      end
      if (upd_go) begin
         if (found) begin
            status_ff <= ST_FOUND;
            slot_ff   <= enc[5:0];
         end else if (action_ff == ACT_LOOKUP) begin
            status_ff <= ST_ABSENT;
            slot_ff   <= '0;
         end else if (full) begin
            status_ff <= ST_FULL;
            slot_ff   <= '0;
         end else begin
            status_ff <= ST_INSERTED;
            slot_ff   <= enc[5:0];
         end
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = status_ff;
   assign rsp_ch.slot   = slot_ff;

endmodule

@@ rtl/skt_checker.sv @@
// Port-level checks for the sorted key table unit, bound to the top level.
// Depends on skt_pkg.
`timescale 1ns / 1ps

module skt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [5:0] rsp_slot
);
   import skt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_slot)))
      else $error("response changed while stalled");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_ABSENT || rsp_status == ST_FULL)) |-> (rsp_slot == 6'd0))
      else $error("nonzero slot on absent or full");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken during compare cycle");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sorted_key_table_lookup_insert_unit skt_checker u_skt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_slot   (rsp_ch.slot)
);
